### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/cfrrm_pkg.sv
// Package: constants, types and helpers of the regret-matching node update unit.
package cfrrm_pkg;

    localparam int ACTIONS    = 4;
    localparam int NODES      = 256;
    localparam int NODE_W     = $clog2(NODES);
    localparam int RT_W       = 40;
    localparam int PRED_W     = 32;
    localparam int Q_W        = 17;
    localparam int SHARE_W    = 60;
    localparam int POS_W      = RT_W;
    localparam int PSUM_W     = POS_W + $clog2(ACTIONS);
    localparam int SSUM_W     = SHARE_W + $clog2(ACTIONS);
    localparam int RATIO_W    = SSUM_W;
    localparam int REACH_W    = 17;
    localparam int ITER_W     = 16;
    localparam int WEIGHT_W   = 2 * ITER_W;
    localparam int SCALED_W   = 18;
    localparam int ADD_W      = SCALED_W + WEIGHT_W;
    localparam int DIV_STEPS  = 17;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int CNT_W      = $clog2(ACTIONS + 1);

    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

    // floor(65536 / k) for k legal actions, k up to eight; entry 0 unused
    localparam int UNIFORM_Q16 [9] = '{0, 65536 / 1, 65536 / 2, 65536 / 3, 65536 / 4,
                                       65536 / 5, 65536 / 6, 65536 / 7, 65536 / 8};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VARIANT = 1'b0,
        CFG_WEIGHT  = 1'b1
    } cfg_index_t;

    localparam logic [1:0] VAR_VANILLA = 2'd0;
    localparam logic [1:0] VAR_PLUS    = 2'd1;
    localparam logic [1:0] VAR_PRED    = 2'd2;

    localparam logic [1:0] WGT_UNIFORM = 2'd0;
    localparam logic [1:0] WGT_LINEAR  = 2'd1;
    localparam logic [1:0] WGT_QUAD    = 2'd2;

    typedef struct packed {
        logic                      rd_en;
        logic                      wr_en;
        logic [NODE_W-1:0]         addr;
        logic                      fresh;
        logic [1:0]                variant;
        logic [REACH_W-1:0]        opp;
        logic [REACH_W-1:0]        own;
        logic [WEIGHT_W-1:0]       weight;
        logic [Q_W-1:0]            uniform;
        logic                      load_mul;
        logic                      load_acc;
        logic                      load_pos;
        logic                      div_first;
        logic                      div_step;
        logic [PSUM_W-1:0]         psum;
        logic [SSUM_W-1:0]         ssum;
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [RT_W-1:0]   rt;
        logic signed [PRED_W-1:0] pred;
        logic [Q_W-1:0]           cur;
        logic [SHARE_W-1:0]       share;
    } node_entry_t;

    // floor(65536 / n), zero when no action is legal
    function automatic logic [Q_W-1:0] uniform_q16(input logic [CNT_W-1:0] n);
        logic [Q_W-1:0] u;
        u = '0;
        for (int k = 1; k <= ACTIONS; k++)
        begin
            if (n == CNT_W'(k))
                u = Q_W'(UNIFORM_Q16[k]);
        end
        return u;
    endfunction

endpackage

### rtl/cfrrm_if.sv
// Valid/ready channel interfaces for node update requests and results.
interface cfrrm_in_if;
    logic                valid;
    logic                ready;
    logic [7:0]          node_index;
    logic signed [31:0]  regret_a0;
    logic signed [31:0]  regret_a1;
    logic signed [31:0]  regret_a2;
    logic signed [31:0]  regret_a3;
    logic [3:0]          legal_mask;
    logic [16:0]         opponent_reach;
    logic [16:0]         self_reach;
    logic [15:0]         iteration_number;

    modport source (output valid, node_index, regret_a0, regret_a1, regret_a2, regret_a3,
                    legal_mask, opponent_reach, self_reach, iteration_number,
                    input ready);
    modport sink (input valid, node_index, regret_a0, regret_a1, regret_a2, regret_a3,
                  legal_mask, opponent_reach, self_reach, iteration_number,
                  output ready);
endinterface

interface cfrrm_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] current_a0;
    logic [16:0] current_a1;
    logic [16:0] current_a2;
    logic [16:0] current_a3;
    logic [16:0] average_a0;
    logic [16:0] average_a1;
    logic [16:0] average_a2;
    logic [16:0] average_a3;

    modport source (output valid, current_a0, current_a1, current_a2, current_a3,
                    average_a0, average_a1, average_a2, average_a3,
                    input ready);
    modport sink (input valid, current_a0, current_a1, current_a2, current_a3,
                  average_a0, average_a1, average_a2, average_a3,
                  output ready);
endinterface

### rtl/cfrrm_ratio.sv
// Restoring divider giving floor(num * 65536 / den) for num <= den, one bit a cycle while step is high.
module cfrrm_ratio (
    input  logic                            clk,
    input  logic                            step,
    input  logic                            first,
    input  logic [cfrrm_pkg::RATIO_W-1:0]   num,
    input  logic [cfrrm_pkg::RATIO_W-1:0]   den,
    output logic [cfrrm_pkg::Q_W-1:0]       quot
);
    import cfrrm_pkg::*;

    logic [RATIO_W:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [RATIO_W:0] trial;
    logic             ge;

    always_comb
    begin
        trial = first ? {1'b0, num} : {rem_reg[RATIO_W-1:0], 1'b0};
        ge = trial >= {1'b0, den};
        rem_next = ge ? (trial - {1'b0, den}) : trial;
        quot_next = first ? {{(Q_W-1){1'b0}}, ge} : {quot_reg[Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
endmodule

### rtl/cfrrm_lane.sv
// One action lane: node memory slice, regret and mass accumulation, two dividers.
module cfrrm_lane (
    input  logic                               clk,
    input  cfrrm_pkg::lane_ctrl_t              ctrl,
    input  logic                               legal,
    input  logic signed [31:0]                 regret,
    output logic [cfrrm_pkg::POS_W-1:0]        pos,
    output logic [cfrrm_pkg::SHARE_W-1:0]      share,
    output logic [cfrrm_pkg::Q_W-1:0]          cur,
    output logic [cfrrm_pkg::Q_W-1:0]          avg
);
    import cfrrm_pkg::*;

    localparam logic signed [RT_W:0] RT_MAX_X = {2'b00, {(RT_W-1){1'b1}}};
    localparam logic signed [RT_W:0] RT_MIN_X = {2'b11, {(RT_W-1){1'b0}}};

    node_entry_t mem [NODES];
    node_entry_t rd_data_reg;
    node_entry_t old_reg, old_next;
    node_entry_t wr_entry;

    logic signed [PRED_W-1:0]  inst_reg;
    logic [SCALED_W-1:0]       scaled_reg;
    logic [ADD_W-1:0]          add_reg;
    logic signed [RT_W-1:0]    rt_reg, rt_next;
    logic signed [PRED_W-1:0]  pred_reg;
    logic [SHARE_W-1:0]        share_reg, share_next;
    logic [POS_W-1:0]          pos_reg, pos_next;

    logic signed [49:0]        reg_prod;
    logic [2*REACH_W-1:0]      own_prod;
    logic signed [RT_W:0]      rt_sum;
    logic signed [RT_W:0]      base;
    logic [SHARE_W:0]          share_sum;
    logic [Q_W-1:0]            quot_cur, quot_avg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
            rd_data_reg <= mem[ctrl.addr];
        if (ctrl.wr_en)
            mem[ctrl.addr] <= wr_entry;
    end

    always_comb
    begin
        // a fresh node reads as cleared, with the uniform strategy pending
        if (ctrl.fresh)
        begin
            old_next.rt    = '0;
            old_next.pred  = '0;
            old_next.cur   = legal ? ctrl.uniform : '0;
            old_next.share = '0;
        end
        else
            old_next = rd_data_reg;
        reg_prod = $signed({1'b0, ctrl.opp}) * regret;
        own_prod = ctrl.own * old_next.cur;
    end

    always_comb
    begin
        rt_sum = {old_reg.rt[RT_W-1], old_reg.rt} + (RT_W+1)'(inst_reg);
        if (rt_sum > RT_MAX_X)
            rt_next = RT_MAX_X[RT_W-1:0];
        else if (rt_sum < RT_MIN_X)
            rt_next = RT_MIN_X[RT_W-1:0];
        else
            rt_next = rt_sum[RT_W-1:0];
        if (ctrl.variant != VAR_VANILLA && rt_next < 0)
            rt_next = '0;
        if (!legal)
            rt_next = old_reg.rt;

        share_sum = {1'b0, old_reg.share} + (SHARE_W+1)'(add_reg);
        share_next = share_sum[SHARE_W] ? {SHARE_W{1'b1}} : share_sum[SHARE_W-1:0];
        if (!legal)
            share_next = old_reg.share;

        base = {rt_reg[RT_W-1], rt_reg};
        if (ctrl.variant == VAR_PRED)
            base = base + (RT_W+1)'(pred_reg);
        pos_next = (legal && base > 0) ? base[POS_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            old_reg    <= old_next;
            inst_reg   <= reg_prod[47:16];
            scaled_reg <= own_prod[2*REACH_W-1:16];
        end
        if (ctrl.load_acc)
        begin
            add_reg  <= scaled_reg * ctrl.weight;
            rt_reg   <= rt_next;
            pred_reg <= (legal && ctrl.variant == VAR_PRED) ? inst_reg : old_reg.pred;
        end
        if (ctrl.load_pos)
        begin
            share_reg <= share_next;
            pos_reg   <= pos_next;
        end
    end

    cfrrm_ratio u_div_cur (
        .clk   (clk),
        .step  (ctrl.div_step),
        .first (ctrl.div_first),
        .num   (RATIO_W'(pos_reg)),
        .den   (RATIO_W'(ctrl.psum)),
        .quot  (quot_cur)
    );

    cfrrm_ratio u_div_avg (
        .clk   (clk),
        .step  (ctrl.div_step),
        .first (ctrl.div_first),
        .num   (RATIO_W'(share_reg)),
        .den   (RATIO_W'(ctrl.ssum)),
        .quot  (quot_avg)
    );

    always_comb
    begin
        cur = '0;
        avg = '0;
        if (legal)
        begin
            cur = (ctrl.psum != '0) ? quot_cur : ctrl.uniform;
            avg = (ctrl.ssum != '0) ? quot_avg : ctrl.uniform;
        end
        wr_entry.rt    = rt_reg;
        wr_entry.pred  = pred_reg;
        wr_entry.cur   = cur;
        wr_entry.share = share_reg;
    end

    assign pos   = pos_reg;
    assign share = share_reg;
endmodule

### rtl/cfrrm_merge.sv
// Merge stage: sums positive regret bases over all lanes, strategy mass over the legal lanes.
module cfrrm_merge (
    input  logic [cfrrm_pkg::POS_W-1:0]    pos   [cfrrm_pkg::ACTIONS],
    input  logic [cfrrm_pkg::SHARE_W-1:0]  share [cfrrm_pkg::ACTIONS],
    input  logic [cfrrm_pkg::ACTIONS-1:0]  legal,
    output logic [cfrrm_pkg::PSUM_W-1:0]   psum,
    output logic [cfrrm_pkg::SSUM_W-1:0]   ssum
);
    import cfrrm_pkg::*;

    always_comb
    begin
        psum = '0;
        ssum = '0;
        for (int i = 0; i < ACTIONS; i++)
        begin
            psum = psum + PSUM_W'(pos[i]);
            if (legal[i])
                ssum = ssum + SSUM_W'(share[i]);
        end
    end
endmodule

### rtl/cfr_regret_matching_node_update_unit.sv
// Top level: sequencer, node freshness bits, configuration and output register.
//
// Regret-matching node update unit.
// in_ch carries one update request per transfer: node index, four per-action
// regrets, legal mask, two reach weights and the iteration. out_ch returns one
// result per request: the new current strategy and the normalised average.
// cfg_we/cfg_index/cfg_data write variant_mode (index 0) and weight_mode
// (index 1); write only while no request is in flight.
// One request is in flight at a time, and a new request is taken only after the
// previous one is written back. Each request passes the node memory read, two
// multiply stages, the mass and regret accumulation, the merge stage and the
// 17-step restoring dividers in each lane (one quotient bit a cycle), then the
// write-back, which also makes the result valid.
// A finished result sits in the output register; the next request is still
// taken and worked on, and only its final write-back waits until out_ch has
// taken the previous result.
// Reset marks every node fresh (reads as cleared, uniform strategy pending),
// so no clearing pass is needed; variant_mode resets to 1, weight_mode to 0.
module cfr_regret_matching_node_update_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    cfrrm_in_if.sink                            in_ch,
    cfrrm_out_if.source                         out_ch,
    input  logic                                cfg_we,
    input  logic [cfrrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfrrm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cfrrm_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic [NODES-1:0]       fresh_reg;
    logic [1:0]             variant_reg;
    logic [1:0]             wmode_reg;
    logic                   out_valid_reg;

    logic [NODE_W-1:0]      node_reg;
    logic [ACTIONS-1:0]     mask_reg;
    logic [REACH_W-1:0]     opp_reg, own_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic signed [31:0]     regret_reg [ACTIONS];
    logic                   fresh_item_reg;
    logic [Q_W-1:0]         uniform_reg;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;
    logic [PSUM_W-1:0]      psum_reg;
    logic [SSUM_W-1:0]      ssum_reg;
    logic [Q_W-1:0]         out_cur_reg [ACTIONS];
    logic [Q_W-1:0]         out_avg_reg [ACTIONS];

    logic                   accept;
    logic                   can_load;
    logic [NODE_W-1:0]      in_node;
    logic [CNT_W-1:0]       in_count;
    logic [REACH_W-1:0]     in_opp, in_own;
    lane_ctrl_t             ctrl;
    logic [POS_W-1:0]       lane_pos   [ACTIONS];
    logic [SHARE_W-1:0]     lane_share [ACTIONS];
    logic [Q_W-1:0]         lane_cur   [ACTIONS];
    logic [Q_W-1:0]         lane_avg   [ACTIONS];
    logic [PSUM_W-1:0]      psum;
    logic [SSUM_W-1:0]      ssum;
    logic [Q_W+1:0]         cur_total;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign can_load    = !out_valid_reg || out_ch.ready;
    assign in_node     = in_ch.node_index[NODE_W-1:0];
    assign in_opp      = (in_ch.opponent_reach > ONE_Q16) ? ONE_Q16 : in_ch.opponent_reach;
    assign in_own      = (in_ch.self_reach > ONE_Q16) ? ONE_Q16 : in_ch.self_reach;

    always_comb
    begin
        in_count = '0;
        for (int i = 0; i < ACTIONS; i++)
            in_count = in_count + CNT_W'(in_ch.legal_mask[i]);
        unique case (wmode_reg)
            WGT_LINEAR: weight_next = WEIGHT_W'(iter_reg);
            WGT_QUAD:   weight_next = iter_reg * iter_reg;
            default:    weight_next = WEIGHT_W'(1);
        endcase
    end

    always_comb
    begin
        ctrl.rd_en     = accept;
        ctrl.wr_en     = (state_reg == S_DONE) && can_load;
        ctrl.addr      = (state_reg == S_IDLE) ? in_node : node_reg;
        ctrl.fresh     = fresh_item_reg;
        ctrl.variant   = variant_reg;
        ctrl.opp       = opp_reg;
        ctrl.own       = own_reg;
        ctrl.weight    = weight_reg;
        ctrl.uniform   = uniform_reg;
        ctrl.load_mul  = (state_reg == S_READ);
        ctrl.load_acc  = (state_reg == S_MUL);
        ctrl.load_pos  = (state_reg == S_ACC);
        ctrl.div_step  = (state_reg == S_DIV);
        ctrl.div_first = (state_reg == S_DIV) && (dcnt_reg == '0);
        ctrl.psum      = psum_reg;
        ctrl.ssum      = ssum_reg;
    end

    for (genvar g = 0; g < ACTIONS; g++)
    begin : g_lane
        cfrrm_lane u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .legal  (mask_reg[g]),
            .regret (regret_reg[g]),
            .pos    (lane_pos[g]),
            .share  (lane_share[g]),
            .cur    (lane_cur[g]),
            .avg    (lane_avg[g])
        );
    end

    cfrrm_merge u_merge (
        .pos   (lane_pos),
        .share (lane_share),
        .legal (mask_reg),
        .psum  (psum),
        .ssum  (ssum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dcnt_reg      <= '0;
            fresh_reg     <= '1;
            variant_reg   <= VAR_PLUS;
            wmode_reg     <= WGT_UNIFORM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_VARIANT: variant_reg <= cfg_data;
                    CFG_WEIGHT:  wmode_reg   <= cfg_data;
                    default:     ;
                endcase
            end
            // a new result may replace the one taken in the same cycle
            if (state_reg == S_DONE && can_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        fresh_reg[in_node] <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_MUL;
                S_MUL:  state_reg <= S_ACC;
                S_ACC:  state_reg <= S_SUM;
                S_SUM:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (can_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg       <= in_node;
            mask_reg       <= in_ch.legal_mask;
            opp_reg        <= in_opp;
            own_reg        <= in_own;
            iter_reg       <= in_ch.iteration_number;
            regret_reg[0]  <= in_ch.regret_a0;
            regret_reg[1]  <= in_ch.regret_a1;
            regret_reg[2]  <= in_ch.regret_a2;
            regret_reg[3]  <= in_ch.regret_a3;
            fresh_item_reg <= fresh_reg[in_node];
            uniform_reg    <= uniform_q16(in_count);
        end
        if (state_reg == S_READ)
            weight_reg <= weight_next;
        if (state_reg == S_SUM)
        begin
            psum_reg <= psum;
            ssum_reg <= ssum;
        end
        if (ctrl.wr_en)
        begin
            out_cur_reg <= lane_cur;
            out_avg_reg <= lane_avg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.current_a0 = out_cur_reg[0];
    assign out_ch.current_a1 = out_cur_reg[1];
    assign out_ch.current_a2 = out_cur_reg[2];
    assign out_ch.current_a3 = out_cur_reg[3];
    assign out_ch.average_a0 = out_avg_reg[0];
    assign out_ch.average_a1 = out_avg_reg[1];
    assign out_ch.average_a2 = out_avg_reg[2];
    assign out_ch.average_a3 = out_avg_reg[3];

    always_comb
    begin
        cur_total = '0;
        for (int i = 0; i < ACTIONS; i++)
            cur_total = cur_total + (Q_W+2)'(out_cur_reg[i]);
    end

    // a stalled result must hold the write-back back
    `ASSERT_NXT(a_hold_done, clk, rst_n,
                state_reg == S_DONE && out_valid_reg && !out_ch.ready, state_reg == S_DONE)
    `ASSERT_NXT(a_accept_read, clk, rst_n, accept, state_reg == S_READ && !fresh_reg[node_reg])
    `ASSERT_IMP(a_div_count, clk, rst_n, state_reg == S_DIV,
                dcnt_reg <= DCNT_W'(DIV_STEPS - 1))
    `ASSERT_IMP(a_strategy_sum, clk, rst_n, out_valid_reg, cur_total <= (Q_W+2)'(ONE_Q16))
endmodule
